@@ rtl/adsr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope scaler package
// Shared widths, register indexes, reset values and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package adsr_pkg;

    // Field and counter widths
    localparam int COUNT_BITS    = 24;
    localparam int SAMPLE_BITS   = 16;
    localparam int GAIN_BITS     = 16;
    localparam int FRAC_BITS     = GAIN_BITS - 1;
    localparam int ACC_BITS      = SAMPLE_BITS + 2;
    localparam int NUM_BITS      = COUNT_BITS + GAIN_BITS;
    localparam int CMP_BITS      = COUNT_BITS + 2;
    localparam int DIV_CNT_BITS  = $clog2(GAIN_BITS + 1);
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = COUNT_BITS;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK_LEN    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_LEN     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE_LEN   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOTAL_LEN     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK_LEVEL  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SUSTAIN_LEVEL = 3'd5;

    // Register reset values
    localparam logic [COUNT_BITS-1:0] RST_ATTACK_LEN    = 24'd800;
    localparam logic [COUNT_BITS-1:0] RST_DECAY_LEN     = 24'd800;
    localparam logic [COUNT_BITS-1:0] RST_RELEASE_LEN   = 24'd800;
    localparam logic [COUNT_BITS-1:0] RST_TOTAL_LEN     = 24'd8000;
    localparam logic [GAIN_BITS-1:0]  RST_ATTACK_LEVEL  = 16'd32768;
    localparam logic [GAIN_BITS-1:0]  RST_SUSTAIN_LEVEL = 16'd16384;

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture sample and phase hits
        logic start;   // launch ramp multiply and divide
        logic scale;   // apply the current gain
        logic finish;  // deliver result, advance counter
        logic rel;     // release pass selected
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_main;  // attack, decay or sustain applies
        logic main_div;   // main phase gain is a ramp
        logic need_rel;   // release applies
        logic div_busy;   // divider running
        logic out_free;   // output register can take a result
    } status_t;

endpackage

@@ rtl/adsr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR ramp divider
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits GAIN_BITS, so the upper dividend part starts below divisor.
// ----------------------------------------------------------------------------
module adsr_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [adsr_pkg::NUM_BITS-1:0]       dividend,
    input  logic [adsr_pkg::COUNT_BITS-1:0]     divisor,
    output logic                                busy,
    output logic [adsr_pkg::GAIN_BITS-1:0]      quotient
);

    logic [adsr_pkg::COUNT_BITS-1:0]   rem_reg, rem_next;
    logic [adsr_pkg::COUNT_BITS-1:0]   den_reg;
    logic [adsr_pkg::GAIN_BITS-1:0]    num_reg, num_next;
    logic [adsr_pkg::DIV_CNT_BITS-1:0] cnt_reg;
    logic [adsr_pkg::COUNT_BITS:0]     trial;
    logic [adsr_pkg::COUNT_BITS:0]     diff;
    logic                              fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial    = {rem_reg, num_reg[adsr_pkg::GAIN_BITS-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? diff[adsr_pkg::COUNT_BITS-1:0] : trial[adsr_pkg::COUNT_BITS-1:0];
        num_next = {num_reg[adsr_pkg::GAIN_BITS-2:0], fits};
    end

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= adsr_pkg::DIV_CNT_BITS'(adsr_pkg::GAIN_BITS);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Remainder and dividend/quotient shift register
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[adsr_pkg::NUM_BITS-1:adsr_pkg::GAIN_BITS];
            num_reg <= dividend[adsr_pkg::GAIN_BITS-1:0];
            den_reg <= divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            num_reg <= num_next;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = num_reg;

endmodule

@@ rtl/adsr_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR datapath
// Configuration registers, note counter, phase decode, ramp gain unit,
// Q1.15 scaling with truncation toward zero, saturation and output register.
// ----------------------------------------------------------------------------
module adsr_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [adsr_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
    input  logic [adsr_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic [adsr_pkg::SAMPLE_BITS-1:0]      s_tdata,
    input  logic                                  m_tready,
    input  adsr_pkg::cmd_t                        cmd,
    output adsr_pkg::status_t                     status,
    output logic                                  m_tvalid,
    output logic [adsr_pkg::SAMPLE_BITS-1:0]      m_tdata,
    output logic                                  m_tuser
);

    localparam logic signed [adsr_pkg::ACC_BITS-1:0] SAT_MAX =
        adsr_pkg::ACC_BITS'((1 << (adsr_pkg::SAMPLE_BITS - 1)) - 1);
    localparam logic signed [adsr_pkg::ACC_BITS-1:0] SAT_MIN =
        -SAT_MAX - adsr_pkg::ACC_BITS'(1);
    localparam int PROD_BITS = adsr_pkg::ACC_BITS + adsr_pkg::GAIN_BITS + 1;
    localparam logic signed [PROD_BITS-1:0] ROUND_BIAS =
        PROD_BITS'((1 << adsr_pkg::FRAC_BITS) - 1);

    // Configuration
    logic [adsr_pkg::COUNT_BITS-1:0] attack_len_reg, decay_len_reg;
    logic [adsr_pkg::COUNT_BITS-1:0] release_len_reg, total_len_reg;
    logic [adsr_pkg::GAIN_BITS-1:0]  attack_level_reg, sustain_level_reg;

    // Item state
    logic [adsr_pkg::COUNT_BITS-1:0]      cnt_reg;
    logic signed [adsr_pkg::ACC_BITS-1:0] x_reg, x_next;
    logic att_reg, dec_reg, sus_reg, rel_reg;
    logic att_hit, dec_hit, sus_hit, rel_hit;

    // Output register
    logic                             out_valid_reg;
    logic [adsr_pkg::SAMPLE_BITS-1:0] out_data_reg;
    logic                             out_last_reg;

    // Phase decode
    logic [adsr_pkg::CMP_BITS-1:0] ie, ae, de, re, te, ad_end, tr_start;

    // Ramp gain
    logic [adsr_pkg::COUNT_BITS-1:0] op_a, den;
    logic [adsr_pkg::GAIN_BITS-1:0]  op_b, lvl_mag, quot, gain;
    logic [adsr_pkg::GAIN_BITS:0]    gain_sum;
    logic [adsr_pkg::NUM_BITS-1:0]   ramp_prod;
    logic                            lvl_up;
    logic                            div_busy;

    // Scaling and saturation
    logic signed [PROD_BITS-1:0]          sc_prod, sc_sum;
    logic signed [adsr_pkg::ACC_BITS-1:0] sat_val;
    logic                                 last;

    // Hold configuration, write on enable
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_len_reg    <= adsr_pkg::RST_ATTACK_LEN;
            decay_len_reg     <= adsr_pkg::RST_DECAY_LEN;
            release_len_reg   <= adsr_pkg::RST_RELEASE_LEN;
            total_len_reg     <= adsr_pkg::RST_TOTAL_LEN;
            attack_level_reg  <= adsr_pkg::RST_ATTACK_LEVEL;
            sustain_level_reg <= adsr_pkg::RST_SUSTAIN_LEVEL;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                adsr_pkg::REG_ATTACK_LEN:    attack_len_reg  <= cfg_data;
                adsr_pkg::REG_DECAY_LEN:     decay_len_reg   <= cfg_data;
                adsr_pkg::REG_RELEASE_LEN:   release_len_reg <= cfg_data;
                adsr_pkg::REG_TOTAL_LEN:     total_len_reg   <= cfg_data;
                adsr_pkg::REG_ATTACK_LEVEL:
                    attack_level_reg  <= cfg_data[adsr_pkg::GAIN_BITS-1:0];
                adsr_pkg::REG_SUSTAIN_LEVEL:
                    sustain_level_reg <= cfg_data[adsr_pkg::GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Decode which phase windows hold the current counter value
    always_comb begin
        ie       = {2'b00, cnt_reg};
        ae       = {2'b00, attack_len_reg};
        de       = {2'b00, decay_len_reg};
        re       = {2'b00, release_len_reg};
        te       = {2'b00, total_len_reg};
        ad_end   = ae + de;
        tr_start = te - re;
        att_hit  = (attack_len_reg != '0) && (ie <= ae);
        dec_hit  = (decay_len_reg != '0) && (ie > ae) && (ie <= ad_end);
        sus_hit  = (ie > ad_end) && ($signed(ie) <= $signed(tr_start));
        rel_hit  = (release_len_reg != '0) && ($signed(ie) > $signed(tr_start))
                   && (ie <= te);
    end

    // Capture sample and phase hits on input transfer
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg   <= adsr_pkg::ACC_BITS'($signed(s_tdata));
            att_reg <= att_hit;
            dec_reg <= dec_hit;
            sus_reg <= sus_hit;
            rel_reg <= rel_hit;
        end else if (cmd.scale) begin
            x_reg   <= x_next;
        end
    end

    // Select ramp operands: numerator factors and length
    always_comb begin
        lvl_up  = (sustain_level_reg > attack_level_reg);
        lvl_mag = lvl_up ? (sustain_level_reg - attack_level_reg)
                         : (attack_level_reg - sustain_level_reg);
        priority if (cmd.rel) begin
            op_a = total_len_reg - cnt_reg;
            op_b = sustain_level_reg;
            den  = release_len_reg;
        end else if (att_reg) begin
            op_a = cnt_reg;
            op_b = attack_level_reg;
            den  = attack_len_reg;
        end else begin
            op_a = cnt_reg - attack_len_reg;
            op_b = lvl_mag;
            den  = decay_len_reg;
        end
        ramp_prod = adsr_pkg::NUM_BITS'(op_a) * adsr_pkg::NUM_BITS'(op_b);
    end

    adsr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start),
        .dividend (ramp_prod),
        .divisor  (den),
        .busy     (div_busy),
        .quotient (quot)
    );

    // Gain of the active pass
    always_comb begin
        priority if (cmd.rel || att_reg) begin
            gain_sum = {1'b0, quot};
        end else if (dec_reg) begin
            gain_sum = lvl_up ? ({1'b0, attack_level_reg} + {1'b0, quot})
                              : ({1'b0, attack_level_reg} - {1'b0, quot});
        end else begin
            gain_sum = {1'b0, sustain_level_reg};
        end
        gain = gain_sum[adsr_pkg::GAIN_BITS-1:0];
    end

    // Scale by Q1.15 gain, truncating toward zero
    always_comb begin
        sc_prod = PROD_BITS'(x_reg) * PROD_BITS'($signed({1'b0, gain}));
        sc_sum  = sc_prod[PROD_BITS-1] ? (sc_prod + ROUND_BIAS) : sc_prod;
        x_next  = sc_sum[adsr_pkg::FRAC_BITS +: adsr_pkg::ACC_BITS];
    end

    // Saturate and detect note end
    always_comb begin
        priority if (x_reg > SAT_MAX) begin
            sat_val = SAT_MAX;
        end else if (x_reg < SAT_MIN) begin
            sat_val = SAT_MIN;
        end else begin
            sat_val = x_reg;
        end
        last = (({1'b0, cnt_reg} + 1'b1) >= {1'b0, total_len_reg});
    end

    // Advance note counter on finish
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.finish) begin
            cnt_reg <= last ? '0 : (cnt_reg + 1'b1);
        end
    end

    // Output register: load on finish, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_data_reg <= sat_val[adsr_pkg::SAMPLE_BITS-1:0];
            out_last_reg <= last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_last_reg;

    assign status.need_main = att_reg | dec_reg | sus_reg;
    assign status.main_div  = att_reg | dec_reg;
    assign status.need_rel  = rel_reg;
    assign status.div_busy  = div_busy;
    assign status.out_free  = ~out_valid_reg | m_tready;

endmodule

@@ rtl/adsr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR controller
// Sequences one sample: main phase gain pass, release gain pass, delivery.
// ----------------------------------------------------------------------------
module adsr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  adsr_pkg::status_t  status,
    output adsr_pkg::cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SEL   = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       pass_reg, pass_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SEL;
                    pass_next  = 1'b0;
                end
            end
            ST_SEL: begin
                if (!pass_reg) begin
                    if (status.need_main) begin
                        state_next = status.main_div ? ST_START : ST_SCALE;
                    end else begin
                        pass_next = 1'b1;
                    end
                end else begin
                    state_next = status.need_rel ? ST_START : ST_DONE;
                end
            end
            ST_START: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!status.div_busy) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (!pass_reg) begin
                    pass_next  = 1'b1;
                    state_next = ST_SEL;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pass_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    // Commands
    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.load   = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.start  = (state_reg == ST_START);
    assign cmd.scale  = (state_reg == ST_SCALE);
    assign cmd.finish = (state_reg == ST_DONE) && status.out_free;
    assign cmd.rel    = pass_reg;

`ifndef SYNTH
    // Never overwrite a result that has not been transferred
    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> status.out_free)
        else $error("result loaded while output register busy");

    // A new sample always begins with the main phase pass
    a_load_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_SEL) && !pass_reg)
        else $error("sample did not start in main pass");

    // Divider runs right after it is launched
    a_div_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> status.div_busy)
        else $error("divider idle after launch");

    // Release scaling completes the sample
    a_rel_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scale && pass_reg) |=> (state_reg == ST_DONE))
        else $error("release pass did not lead to delivery");
`endif

endmodule

@@ rtl/adsr_envelope_scaler.sv @@
`timescale 1ns / 1ps
// Samples are processed one at a time: a new input is accepted only after the
//   previous result is loaded into the output register; each ramp gain (attack,
//   decay, release) uses a 16-step restoring divider, at most twice per sample.
// A finished result waits in the output register while the next sample runs.
// Reset (aresetn low, synchronous): counter to 0, registers to defaults,
//   output register empty.
// ----------------------------------------------------------------------------
// ADSR envelope scaler
// Multiplies a stream of signed samples by an attack-decay-sustain-release
// envelope indexed by a wrapping per-note sample counter.
// ----------------------------------------------------------------------------
module adsr_envelope_scaler (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [adsr_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
    input  logic [adsr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [adsr_pkg::SAMPLE_BITS-1:0]    s_tdata,   // [15:0] sample_in
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [adsr_pkg::SAMPLE_BITS-1:0]    m_tdata,   // [15:0] sample_out
    output logic                                m_tuser    // [0] note_end
);

    adsr_pkg::cmd_t    cmd;
    adsr_pkg::status_t status;

    adsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    adsr_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ bench/adsr_envelope_scaler_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope scaler testbench
// Streams signed samples through the scaler under a series of envelope
// settings and checks every result against a cycle-free model of the
// envelope gains, the saturation and the per-note sample counter.
// ----------------------------------------------------------------------------
module adsr_envelope_scaler_test;
    import adsr_pkg::*;

    localparam int     STALL_LIMIT  = 5000;
    localparam int     RANDOM_ITEMS = 1550;
    localparam int     SETTLE_TIME  = 60;
    localparam longint MAX_LEN      = 64'hFF_FFFF;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_out;
        logic                   note_end;
    } envelope_result_t;

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [SAMPLE_BITS-1:0]   s_tdata  = '0;   // [15:0] sample_in
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [SAMPLE_BITS-1:0]   m_tdata;         // [15:0] sample_out
    logic                     m_tuser;         // [0] note_end

    // Envelope settings and note position as the block should hold them
    longint env_attack_len    = longint'(RST_ATTACK_LEN);
    longint env_decay_len     = longint'(RST_DECAY_LEN);
    longint env_release_len   = longint'(RST_RELEASE_LEN);
    longint env_total_len     = longint'(RST_TOTAL_LEN);
    longint env_attack_level  = longint'(RST_ATTACK_LEVEL);
    longint env_sustain_level = longint'(RST_SUSTAIN_LEVEL);
    longint env_position      = 0;

    logic [SAMPLE_BITS-1:0] sample_queue[$];
    envelope_result_t       expected_results[$];

    int send_idle_pct  = 34;
    int recv_idle_pct  = 86;
    int mismatch_count = 0;
    int idle_cycles    = 0;

    adsr_envelope_scaler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Apply every gain window that covers the current position, saturate,
    // then advance or wrap the note position.
    function automatic envelope_result_t predict_envelope(input logic [SAMPLE_BITS-1:0] raw);
        logic signed [SAMPLE_BITS-1:0] smp;
        longint pos, acc;
        envelope_result_t res;
        smp = raw;
        acc = longint'(smp);
        pos = env_position;
        if (env_attack_len > 0 && pos <= env_attack_len)
            acc = acc * ((pos * env_attack_level) / env_attack_len) / 32768;
        if (env_decay_len > 0 && pos > env_attack_len
                && pos <= env_attack_len + env_decay_len)
            acc = acc * (env_attack_level - ((pos - env_attack_len)
                  * (env_attack_level - env_sustain_level)) / env_decay_len) / 32768;
        if (pos > env_attack_len + env_decay_len && pos <= env_total_len - env_release_len)
            acc = acc * env_sustain_level / 32768;
        if (env_release_len > 0 && pos > env_total_len - env_release_len
                && pos <= env_total_len)
            acc = acc * (((env_total_len - pos) * env_sustain_level) / env_release_len)
                  / 32768;
        if (acc > 32767)
            acc = 32767;
        if (acc < -32768)
            acc = -32768;
        res.sample_out = acc[SAMPLE_BITS-1:0];
        res.note_end   = (pos + 1 >= env_total_len);
        if (res.note_end)
            env_position = 0;
        else
            env_position = (pos + 1) & 64'hFF_FFFF;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Driver: hold the item until its transfer, then load the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_envelope(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata  <= sample_queue.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge aclk) begin : result_monitor
        envelope_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h note_end %b",
                                              m_tdata, m_tuser));
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.sample_out)
                        report_mismatch($sformatf("sample_out %h, want %h",
                                                  m_tdata, want.sample_out));
                    if (m_tuser !== want.note_end)
                        report_mismatch($sformatf("note_end %b, want %b",
                                                  m_tuser, want.note_end));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run when nothing transfers for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] corner_sample(input int k);
        case (k % 6)
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'h0001;
            default: return 16'hC000;
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        if ($urandom_range(7) == 0)
            return corner_sample($urandom_range(5));
        return SAMPLE_BITS'($urandom);
    endfunction

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx, input longint value);
        @(posedge aclk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[CFG_DATA_BITS-1:0];
        case (idx)
            REG_ATTACK_LEN:    env_attack_len    = value & 64'hFF_FFFF;
            REG_DECAY_LEN:     env_decay_len     = value & 64'hFF_FFFF;
            REG_RELEASE_LEN:   env_release_len   = value & 64'hFF_FFFF;
            REG_TOTAL_LEN:     env_total_len     = value & 64'hFF_FFFF;
            REG_ATTACK_LEVEL:  env_attack_level  = value & 64'hFFFF;
            REG_SUSTAIN_LEVEL: env_sustain_level = value & 64'hFFFF;
            default: ;
        endcase
    endtask

    task automatic setup_envelope(input longint a, input longint d, input longint r,
                                  input longint t, input longint al, input longint sl);
        write_register(REG_ATTACK_LEN, a);
        write_register(REG_DECAY_LEN, d);
        write_register(REG_RELEASE_LEN, r);
        write_register(REG_TOTAL_LEN, t);
        write_register(REG_ATTACK_LEVEL, al);
        write_register(REG_SUSTAIN_LEVEL, sl);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Queue a batch of samples and wait until every result is back;
    // check between edges so the driver's update of the same edge is seen
    task automatic play_samples(input int count, input bit corners);
        for (int k = 0; k < count; k++)
            sample_queue.push_back(corners ? corner_sample(k) : random_sample());
        do
            @(negedge aclk);
        while (sample_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    function automatic longint pick_level();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 32768;
            default: return longint'($urandom_range(32768, 0));
        endcase
    endfunction

    function automatic longint pick_long_length();
        case ($urandom_range(3))
            0:       return 0;
            1:       return MAX_LEN;
            default: return longint'($urandom & 32'hFF_FFFF);
        endcase
    endfunction

    function automatic longint pick_short_length();
        if ($urandom_range(4) == 0)
            return 0;
        return longint'($urandom_range(12, 1));
    endfunction

    initial begin
        int played;
        int batch;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: start of the attack ramp
        play_samples(3, 1'b1);
        // Short phases with a peak level above unity: saturation
        setup_envelope(2, 2, 2, 8, 65535, 32768);
        play_samples(8, 1'b1);
        // All phases zero length: only position 0 passes, the rest get zero sustain
        setup_envelope(0, 0, 0, 3, 0, 0);
        play_samples(3, 1'b1);
        // Zero total length: every sample ends a note
        setup_envelope(0, 0, 0, 0, 32768, 16384);
        play_samples(2, 1'b1);
        // Overlapping windows multiply
        setup_envelope(4, 4, 6, 6, 32768, 20000);
        play_samples(6, 1'b1);
        // Total lowered below the running position ends the note at once
        setup_envelope(5, 5, 5, 1000, 30000, 10000);
        play_samples(3, 1'b1);
        setup_envelope(5, 5, 5, 2, 30000, 10000);
        play_samples(2, 1'b1);
        // Largest lengths
        setup_envelope(MAX_LEN, MAX_LEN, MAX_LEN, MAX_LEN, 32768, 0);
        play_samples(2, 1'b1);

        // Random envelopes: mostly short notes, some very long ones
        played = 0;
        while (played < RANDOM_ITEMS) begin
            if (played < RANDOM_ITEMS / 3) begin
                send_idle_pct = 34;
                recv_idle_pct = 86;
            end else if (played < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 86;
                recv_idle_pct = 34;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(7) == 0) begin
                setup_envelope(pick_long_length(), pick_long_length(), pick_long_length(),
                               $urandom_range(1) ? MAX_LEN
                                                 : longint'($urandom_range(32'hFF_FFFF, 1)),
                               pick_level(), pick_level());
                batch = $urandom_range(30, 10);
            end else begin
                setup_envelope(pick_short_length(), pick_short_length(), pick_short_length(),
                               longint'($urandom_range(60, 1)), pick_level(), pick_level());
                batch = $urandom_range(120, 40);
            end
            play_samples(batch, 1'b0);
            played += batch;
        end

        // Let any stray result show up before the verdict
        repeat (SETTLE_TIME) @(posedge aclk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
